[design/vertex_project_to_screen_defines.svh]
// Assertion macros shared by the vertex projection design.
`ifndef VERTEX_PROJECT_TO_SCREEN_DEFINES_SVH
`define VERTEX_PROJECT_TO_SCREEN_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define VPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed: label");

// The antecedent implies the consequent in the next cycle.
`define VPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed: label");

`endif

[design/vps_pkg.sv]
// Package with widths, types and reset values for the vertex projection block.
package vps_pkg;
    localparam int unsigned CoordW  = 16;
    localparam int unsigned CoefW   = 32;
    localparam int unsigned RegW    = 64;
    localparam int unsigned NumRegs = 8;
    localparam int unsigned AddrW   = 6;
    localparam int unsigned ProdW   = CoefW + CoordW;
    localparam int unsigned SumW    = 50;
    localparam int unsigned QW      = 16;
    localparam int unsigned RemW    = SumW + QW;

    typedef logic [RegW-1:0] t_reg;

    localparam t_reg RegReset [NumRegs] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_0001_0000,
        64'h0,                   64'h0001_0000_0000_0000
    };

    typedef struct packed {
        logic [RemW-1:0] rx;
        logic [RemW-1:0] ry;
        logic [SumW-1:0] aw;
        logic [QW-1:0]   qx;
        logic [QW-1:0]   qy;
        logic            nx;
        logic            ny;
        logic            ox;
        logic            oy;
        logic            wz;
    } t_div;
endpackage

[design/vps_if.sv]
// Stream interfaces for vertices in and screen points out.
interface vps_vtx_if import vps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CoordW-1:0] vert_x;
    logic [CoordW-1:0] vert_y;
    logic [CoordW-1:0] vert_z;
    modport source (output valid, vert_x, vert_y, vert_z, input ready);
    modport sink (input valid, vert_x, vert_y, vert_z, output ready);
endinterface

interface vps_scr_if import vps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CoordW-1:0] screen_x;
    logic [CoordW-1:0] screen_y;
    logic              w_zero;
    logic              clipped;
    modport source (output valid, screen_x, screen_y, w_zero, clipped, input ready);
    modport sink (input valid, screen_x, screen_y, w_zero, clipped, output ready);
endinterface

[design/vertex_project_to_screen.sv]
// Top level: 4x4 vertex transform with perspective divide, fully pipelined.
//  channel  | direction | transaction
//  i_vtx    | in        | one vertex x, y, z (Q8.8)
//  o_scr    | out       | screen x, y, w_zero, clipped
//  APB      | in/out    | 64-bit matrix register writes and reads
// One vertex enters per cycle while the pipeline does not stall; each passes through the products,
// the row sums, the divide setup, sixteen restoring divide steps and saturation.
// Every stage has its own valid bit and stalls only while the stage after it, or o_scr, cannot accept.
// Synchronous active-low reset clears the valid bits and restores the identity matrix.
`include "vertex_project_to_screen_defines.svh"
module vertex_project_to_screen import vps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vps_vtx_if.sink          i_vtx,
    vps_scr_if.source        o_scr,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [RegW-1:0]  pwdata,
    output logic [RegW-1:0]  prdata,
    output logic             pready
);
    localparam int unsigned NStg = 20;
    localparam int unsigned DivN = QW + 1;

    t_reg r_cfg [NumRegs];
    logic [NStg-1:0] r_vld;
    logic [NStg:0]   w_rdy;

    logic signed [ProdW-1:0] r_prod [3][3];
    logic signed [ProdW-1:0] n_prod [3][3];
    logic signed [SumW-1:0]  r_c3 [3];
    logic signed [SumW-1:0]  n_c3 [3];
    logic signed [SumW-1:0]  r_sum [3];
    logic signed [SumW-1:0]  n_sum [3];
    t_div r_div [DivN];
    t_div n_div [DivN];
    logic [CoordW-1:0] r_sx, r_sy, n_sx, n_sy;
    logic r_wz, r_clip, n_wz, n_clip;

    assign pready = 1'b1;
    assign prdata = r_cfg[paddr[AddrW-1:3]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumRegs; i++) r_cfg[i] <= RegReset[i];
        end else if (psel && penable && pwrite) begin
            r_cfg[paddr[AddrW-1:3]] <= pwdata;
        end
    end

    assign w_rdy[NStg] = o_scr.ready;
    for (genvar k = 0; k < NStg; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end
    assign i_vtx.ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_vtx.valid;
            end
            for (int k = 1; k < NStg; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        logic signed [CoordW-1:0] v [3];
        logic signed [CoefW-1:0]  c;
        int unsigned              row;
        v[0] = i_vtx.vert_x;
        v[1] = i_vtx.vert_y;
        v[2] = i_vtx.vert_z;
        for (int r = 0; r < 3; r++) begin
            row = (r == 2) ? 3 : r;
            for (int col = 0; col < 3; col++) begin
                c = (col % 2 == 1) ? r_cfg[row*2 + col/2][63:32]
                                   : r_cfg[row*2 + col/2][31:0];
                n_prod[r][col] = ProdW'(c * v[col]);
            end
            c = r_cfg[row*2 + 1][63:32];
            n_c3[r] = SumW'(c) <<< 8;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = SumW'(r_prod[r][0]) + SumW'(r_prod[r][1])
                     + SumW'(r_prod[r][2]) + r_c3[r];
        end
    end

    always_comb begin
        logic [SumW-1:0] ax, ay;
        logic [RemW-1:0] sub;
        ax = r_sum[0][SumW-1] ? SumW'(-r_sum[0]) : SumW'(r_sum[0]);
        ay = r_sum[1][SumW-1] ? SumW'(-r_sum[1]) : SumW'(r_sum[1]);
        n_div[0].aw = r_sum[2][SumW-1] ? SumW'(-r_sum[2]) : SumW'(r_sum[2]);
        n_div[0].rx = RemW'(ax);
        n_div[0].ry = RemW'(ay);
        n_div[0].qx = '0;
        n_div[0].qy = '0;
        n_div[0].nx = r_sum[0][SumW-1] ^ r_sum[2][SumW-1];
        n_div[0].ny = r_sum[1][SumW-1] ^ r_sum[2][SumW-1];
        n_div[0].ox = RemW'(ax) >= {n_div[0].aw, {QW{1'b0}}};
        n_div[0].oy = RemW'(ay) >= {n_div[0].aw, {QW{1'b0}}};
        n_div[0].wz = (r_sum[2] == '0);
        for (int d = 1; d < DivN; d++) begin
            n_div[d] = r_div[d-1];
            sub = RemW'(r_div[d-1].aw) << (QW - d);
            if (r_div[d-1].rx >= sub) begin
                n_div[d].rx = r_div[d-1].rx - sub;
                n_div[d].qx[QW-d] = 1'b1;
            end
            if (r_div[d-1].ry >= sub) begin
                n_div[d].ry = r_div[d-1].ry - sub;
                n_div[d].qy[QW-d] = 1'b1;
            end
        end
    end

    always_comb begin
        t_div f;
        logic cx, cy;
        f = r_div[DivN-1];
        if (f.nx) begin
            cx = f.ox || (f.qx > 16'd32768);
            n_sx = cx ? 16'h8000 : 16'(-f.qx);
        end else begin
            cx = f.ox || f.qx[QW-1];
            n_sx = cx ? 16'h7fff : f.qx;
        end
        if (f.ny) begin
            cy = f.oy || (f.qy > 16'd32768);
            n_sy = cy ? 16'h8000 : 16'(-f.qy);
        end else begin
            cy = f.oy || f.qy[QW-1];
            n_sy = cy ? 16'h7fff : f.qy;
        end
        n_wz = f.wz;
        n_clip = !f.wz && (cx || cy);
        if (f.wz) begin
            n_sx = '0;
            n_sy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_prod <= n_prod;
            r_c3 <= n_c3;
        end
        if (w_rdy[1]) r_sum <= n_sum;
        for (int d = 0; d < DivN; d++) begin
            if (w_rdy[d+2]) r_div[d] <= n_div[d];
        end
        if (w_rdy[NStg-1]) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_wz <= n_wz;
            r_clip <= n_clip;
        end
    end

    assign o_scr.valid    = r_vld[NStg-1];
    assign o_scr.screen_x = r_sx;
    assign o_scr.screen_y = r_sy;
    assign o_scr.w_zero   = r_wz;
    assign o_scr.clipped  = r_clip;

    `VPS_ASSERT_SAME(a_wz_zero, r_vld[NStg-1] && r_wz,
        r_sx == '0 && r_sy == '0 && !r_clip)
    `VPS_ASSERT_SAME(a_clip_sat, r_vld[NStg-1] && r_clip,
        r_sx == 16'h7fff || r_sx == 16'h8000 || r_sy == 16'h7fff || r_sy == 16'h8000)
    `VPS_ASSERT_NEXT(a_enter, i_vtx.valid && w_rdy[0], r_vld[0])
endmodule
